// ===== src/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants of the circular byte FIFO.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH   = 1024;
    localparam int MAX_POP = 64;

    // Field widths fixed by the interface.
    localparam int CNT_W  = 11;
    localparam int BYTE_W = 8;
    localparam int POP_W  = 7;
    localparam int IDX_W  = $clog2(DEPTH);

    localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
    localparam logic [POP_W-1:0] MAX_POP_C = POP_W'(MAX_POP);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_POP_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        command_t            command;
        logic [BYTE_W-1:0]   data_byte;
        logic                chunk_first;
        logic [CNT_W-1:0]    chunk_length;
        logic [POP_W-1:0]    max_count;
    } in_item_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   out_byte;
        logic                last;
        logic [CNT_W-1:0]    free_space;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_READ,
        ST_POP_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_push;
        logic start_pop;
        logic pop_error;
        logic pop_read;
        logic pop_emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;
        logic pop_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/brb_ctrl.sv =====
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer that accepts items and steps a pop request through its bytes.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  brb_pkg::command_t   command,
    input  brb_pkg::dp_status_t dp_status,
    output logic                s_ready,
    output brb_pkg::ctrl_cmd_t  ctrl_cmd
);

    brb_pkg::state_t state_reg;
    brb_pkg::state_t state_next;
    logic            accept;

    assign s_ready = (state_reg == brb_pkg::ST_IDLE) && dp_status.out_free;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            brb_pkg::ST_IDLE: begin
                if (accept && command == brb_pkg::CMD_POP && dp_status.pop_ok) begin
                    state_next = brb_pkg::ST_POP_READ;
                end
            end
            brb_pkg::ST_POP_READ: begin
                state_next = brb_pkg::ST_POP_EMIT;
            end
            brb_pkg::ST_POP_EMIT: begin
                if (dp_status.out_free) begin
                    state_next = dp_status.pop_done ? brb_pkg::ST_IDLE
                                                    : brb_pkg::ST_POP_READ;
                end
            end
            default: begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl_cmd = '0;
        case (state_reg)
            brb_pkg::ST_IDLE: begin
                if (accept) begin
                    ctrl_cmd.take_push = (command == brb_pkg::CMD_PUSH);
                    ctrl_cmd.start_pop = (command == brb_pkg::CMD_POP) && dp_status.pop_ok;
                    ctrl_cmd.pop_error = (command == brb_pkg::CMD_POP) && !dp_status.pop_ok;
                end
            end
            brb_pkg::ST_POP_READ: begin
                ctrl_cmd.pop_read = 1'b1;
            end
            brb_pkg::ST_POP_EMIT: begin
                ctrl_cmd.pop_emit = dp_status.out_free;
            end
            default: begin
                ctrl_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/brb_datapath.sv =====
// ----------------------------------------------------------------------------
// brb_datapath
// Byte store, ring indices, chunk tracking and the result register.
// ----------------------------------------------------------------------------
module brb_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [brb_pkg::CNT_W-1:0]  cfg_wdata,
    input  brb_pkg::in_item_t          s_data,
    input  brb_pkg::ctrl_cmd_t         ctrl_cmd,
    output brb_pkg::dp_status_t        dp_status,
    input  logic                       m_ready,
    output logic                       m_valid,
    output brb_pkg::out_item_t         m_data
);

    logic [brb_pkg::BYTE_W-1:0] mem [brb_pkg::DEPTH];
    logic [brb_pkg::BYTE_W-1:0] mem_q;

    logic [brb_pkg::CNT_W-1:0] size_reg, size_next;
    logic [brb_pkg::CNT_W-1:0] free_reg, free_next;
    logic [brb_pkg::IDX_W-1:0] rd_reg, rd_next;
    logic [brb_pkg::IDX_W-1:0] wr_reg, wr_next;
    logic [brb_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic                      rej_reg, rej_next;
    logic [brb_pkg::POP_W-1:0] left_reg, left_next;
    logic                      m_valid_reg, m_valid_next;
    brb_pkg::out_item_t        m_data_reg, m_data_next;

    logic [brb_pkg::CNT_W-1:0] occ;
    logic [brb_pkg::POP_W-1:0] count_sat;
    logic [brb_pkg::CNT_W-1:0] pop_n;
    logic [brb_pkg::CNT_W-1:0] wr_inc, rd_inc;
    logic [brb_pkg::IDX_W-1:0] wr_wrap, rd_wrap;
    logic [brb_pkg::CNT_W-1:0] cfg_size;

    // Push decision.
    logic                      push_store;
    brb_pkg::status_t          push_status;
    logic [brb_pkg::CNT_W-1:0] push_rem;
    logic                      push_rej;
    logic [brb_pkg::CNT_W-1:0] push_free;

    assign occ       = size_reg - free_reg;
    assign count_sat = (s_data.max_count > brb_pkg::MAX_POP_C) ? brb_pkg::MAX_POP_C
                                                              : s_data.max_count;
    assign pop_n     = (brb_pkg::CNT_W'(count_sat) < occ) ? brb_pkg::CNT_W'(count_sat) : occ;

    assign wr_inc  = brb_pkg::CNT_W'(wr_reg) + brb_pkg::CNT_W'(1);
    assign rd_inc  = brb_pkg::CNT_W'(rd_reg) + brb_pkg::CNT_W'(1);
    assign wr_wrap = (wr_inc >= size_reg) ? '0 : wr_inc[brb_pkg::IDX_W-1:0];
    assign rd_wrap = (rd_inc >= size_reg) ? '0 : rd_inc[brb_pkg::IDX_W-1:0];

    assign cfg_size = (cfg_wdata == '0) ? brb_pkg::CNT_W'(1)
                    : (cfg_wdata > brb_pkg::DEPTH_C) ? brb_pkg::DEPTH_C : cfg_wdata;

    assign dp_status.pop_ok   = (occ != '0) && (count_sat != '0);
    assign dp_status.pop_done = (left_reg == '0);
    assign dp_status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        logic [brb_pkg::CNT_W-1:0] len;
        len         = (s_data.chunk_length == '0) ? brb_pkg::CNT_W'(1) : s_data.chunk_length;
        push_store  = 1'b0;
        push_status = brb_pkg::STATUS_OK;
        push_rem    = rem_reg;
        push_rej    = rej_reg;
        if (s_data.chunk_first) begin
            push_rem = len - brb_pkg::CNT_W'(1);
            if (len > free_reg) begin
                push_rej    = 1'b1;
                push_status = brb_pkg::STATUS_OVERFLOW;
            end else begin
                push_rej = 1'b0;
                if (free_reg == '0) begin
                    push_status = brb_pkg::STATUS_OVERFLOW;
                end else begin
                    push_store = 1'b1;
                end
            end
        end else if (rem_reg == '0) begin
            push_status = brb_pkg::STATUS_OVERFLOW;
        end else begin
            push_rem = rem_reg - brb_pkg::CNT_W'(1);
            if (rej_reg || free_reg == '0) begin
                push_status = brb_pkg::STATUS_OVERFLOW;
            end else begin
                push_store = 1'b1;
            end
        end
        // A chunk with nothing more to come is closed.
        if (push_rem == '0) begin
            push_rej = 1'b0;
        end
        push_free = push_store ? free_reg - brb_pkg::CNT_W'(1) : free_reg;
    end

    always_comb begin
        size_next    = size_reg;
        free_next    = free_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        rem_next     = rem_reg;
        rej_next     = rej_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (ctrl_cmd.take_push) begin
            rem_next     = push_rem;
            rej_next     = push_rej;
            free_next    = push_free;
            if (push_store) begin
                wr_next = wr_wrap;
            end
            m_valid_next = 1'b1;
            m_data_next  = '{status: push_status, out_byte: '0, last: 1'b1,
                             free_space: push_free};
        end

        if (ctrl_cmd.pop_error) begin
            m_valid_next = 1'b1;
            m_data_next  = '{status: brb_pkg::STATUS_POP_ERROR, out_byte: '0, last: 1'b1,
                             free_space: free_reg};
        end

        if (ctrl_cmd.start_pop) begin
            left_next = pop_n[brb_pkg::POP_W-1:0];
        end

        // The byte is read from the ring into mem_q here; the emit step then loads it into the result register.
        if (ctrl_cmd.pop_read) begin
            rd_next   = rd_wrap;
            free_next = free_reg + brb_pkg::CNT_W'(1);
            left_next = left_reg - brb_pkg::POP_W'(1);
        end

        if (ctrl_cmd.pop_emit) begin
            m_valid_next = 1'b1;
            m_data_next  = '{status: brb_pkg::STATUS_OK, out_byte: mem_q,
                             last: (left_reg == '0), free_space: free_reg};
        end

        if (cfg_we) begin
            size_next = cfg_size;
            free_next = cfg_size;
            rd_next   = '0;
            wr_next   = '0;
            rem_next  = '0;
            rej_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= brb_pkg::DEPTH_C;
            free_reg    <= brb_pkg::DEPTH_C;
            rd_reg      <= '0;
            wr_reg      <= '0;
            rem_reg     <= '0;
            rej_reg     <= 1'b0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            size_reg    <= size_next;
            free_reg    <= free_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            rem_reg     <= rem_next;
            rej_reg     <= rej_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.take_push && push_store) begin
            mem[wr_reg] <= s_data.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.pop_read) begin
            mem_q <= mem[rd_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_free_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= size_reg)
        else $error("free space exceeds ring size");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (brb_pkg::CNT_W'(rd_reg) < size_reg) && (brb_pkg::CNT_W'(wr_reg) < size_reg))
        else $error("ring index beyond ring size");

    a_pop_starts_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.start_pop |=> (left_reg != '0))
        else $error("pop started with no bytes to move");

    a_emit_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.take_push || ctrl_cmd.pop_error || ctrl_cmd.pop_emit)
            |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

endmodule

// ===== src/byte_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte FIFO with chunked pushes and counted pops.
// ----------------------------------------------------------------------------
// The s_ channel takes one item per handshake: a push byte or a pop request.
// The m_ channel returns result items through an output register, so a new
// item can be taken in the cycle in which a waiting result is taken.
// A push item gives exactly one result, registered in the cycle after acceptance; with
// m_ready high pushes stream at one item per cycle.
// A pop request gives min(max_count, 64, occupancy) results, the final one with
// last set, or one error result. Each popped byte takes a registered read of
// the byte store, then a load of the result register, which waits while a result is stalled.
// No new item is taken until the last result of a pop has been loaded.
// When a result waits and m_ready is low, the result register holds and s_ready drops.
// cfg_we writes the ring size and empties the ring; write it only when idle.
// After reset the ring is empty with 1024 slots; no clearing pass is run, as
// only bytes that were written are ever read back.
// ----------------------------------------------------------------------------
module byte_ring_buffer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  brb_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output brb_pkg::out_item_t         m_data,
    input  logic                       cfg_we,
    input  logic [brb_pkg::CNT_W-1:0]  cfg_wdata
);

    brb_pkg::ctrl_cmd_t  ctrl_cmd;
    brb_pkg::dp_status_t dp_status;

    brb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .command   (s_data.command),
        .dp_status (dp_status),
        .s_ready   (s_ready),
        .ctrl_cmd  (ctrl_cmd)
    );

    brb_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
